@@ design/tswg_pkg.sv @@
package tswg_pkg;

   // item kind carried in the mode field
   typedef enum logic [1:0] {
      MODE_RX_TCP6   = 2'd0,
      MODE_RX_OTHER  = 2'd1,
      MODE_TX        = 2'd2,
      MODE_TX_TRUNC  = 2'd3
   } mode_type;

   // result verdict codes
   typedef enum logic [1:0] {
      VERDICT_PASS    = 2'd0,
      VERDICT_DROP    = 2'd1,
      VERDICT_FORWARD = 2'd2,
      VERDICT_ABORT   = 2'd3
   } verdict_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_PEER_ADDR_HI  = 3'd0,
      CSR_PEER_ADDR_LO  = 3'd1,
      CSR_LOCAL_ADDR_HI = 3'd2,
      CSR_LOCAL_ADDR_LO = 3'd3,
      CSR_FLOW_PORTS    = 3'd4,
      CSR_WINDOW_SCALE  = 3'd5,
      CSR_FLOW_RUNNING  = 3'd6
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // tcp header bytes removed from the ipv6 payload length
   localparam logic [15:0] TCP_HDR_BYTES = 16'd20;

   typedef struct packed {
      mode_type    mode;
      logic [63:0] src_addr_hi;
      logic [63:0] src_addr_lo;
      logic [63:0] dst_addr_hi;
      logic [63:0] dst_addr_lo;
      logic [31:0] port_pair;
      logic [31:0] seq_number;
      logic [31:0] ack_number;
      logic [15:0] adv_window;
      logic        syn_flag;
      logic [15:0] ipv6_plen;
      logic [15:0] old_checksum;
   } req_word_type;

   typedef struct packed {
      verdict_type verdict;
      logic [31:0] out_seq;
      logic [15:0] out_checksum;
   } rsp_word_type;

   typedef struct packed {
      logic [63:0] peer_addr_hi;
      logic [63:0] peer_addr_lo;
      logic [63:0] local_addr_hi;
      logic [63:0] local_addr_lo;
      logic [31:0] flow_ports;
      logic [3:0]  window_scale;
      logic        flow_running;
   } cfg_type;

endpackage

@@ design/tswg_req_if.sv @@
interface tswg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [63:0] src_addr_hi;
   logic [63:0] src_addr_lo;
   logic [63:0] dst_addr_hi;
   logic [63:0] dst_addr_lo;
   logic [31:0] port_pair;
   logic [31:0] seq_number;
   logic [31:0] ack_number;
   logic [15:0] adv_window;
   logic        syn_flag;
   logic [15:0] ipv6_plen;
   logic [15:0] old_checksum;

   modport source (
      output valid, mode, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo,
             port_pair, seq_number, ack_number, adv_window, syn_flag,
             ipv6_plen, old_checksum,
      input  ready
   );

   modport sink (
      input  valid, mode, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo,
             port_pair, seq_number, ack_number, adv_window, syn_flag,
             ipv6_plen, old_checksum,
      output ready
   );
endinterface

@@ design/tswg_rsp_if.sv @@
interface tswg_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [31:0] out_seq;
   logic [15:0] out_checksum;

   modport source (
      output valid, verdict, out_seq, out_checksum,
      input  ready
   );

   modport sink (
      input  valid, verdict, out_seq, out_checksum,
      output ready
   );
endinterface

@@ design/tswg_csr_regs.sv @@
module tswg_csr_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [tswg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tswg_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   output tswg_pkg::cfg_type                    cfg
);

   tswg_pkg::cfg_type cfg_ff;
   tswg_pkg::cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (tswg_pkg::csr_index_type'(csr_index))
            tswg_pkg::CSR_PEER_ADDR_HI:  cfg_in.peer_addr_hi  = csr_wr_data;
            tswg_pkg::CSR_PEER_ADDR_LO:  cfg_in.peer_addr_lo  = csr_wr_data;
            tswg_pkg::CSR_LOCAL_ADDR_HI: cfg_in.local_addr_hi = csr_wr_data;
            tswg_pkg::CSR_LOCAL_ADDR_LO: cfg_in.local_addr_lo = csr_wr_data;
            tswg_pkg::CSR_FLOW_PORTS:    cfg_in.flow_ports    = csr_wr_data[31:0];
            tswg_pkg::CSR_WINDOW_SCALE:  cfg_in.window_scale  = csr_wr_data[3:0];
            tswg_pkg::CSR_FLOW_RUNNING:  cfg_in.flow_running  = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/tswg_req_stage.sv @@
module tswg_req_stage (
   input  logic                  clock,
   input  logic                  reset,
   tswg_req_if.sink              req_ch,
   input  logic                  rsp_free,
   output logic                  stage_valid,
   output tswg_pkg::req_word_type stage_word
);

   logic                   valid_ff;
   logic                   valid_in;
   tswg_pkg::req_word_type word_ff;
   logic                   take;

   // stage empties whenever the result register can take its word
   assign req_ch.ready = !valid_ff || rsp_free;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_free) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // header fields captured on accept
   always_ff @(posedge clock) begin
      if (take) begin
         word_ff.mode         <= tswg_pkg::mode_type'(req_ch.mode);
         word_ff.src_addr_hi  <= req_ch.src_addr_hi;
         word_ff.src_addr_lo  <= req_ch.src_addr_lo;
         word_ff.dst_addr_hi  <= req_ch.dst_addr_hi;
         word_ff.dst_addr_lo  <= req_ch.dst_addr_lo;
         word_ff.port_pair    <= req_ch.port_pair;
         word_ff.seq_number   <= req_ch.seq_number;
         word_ff.ack_number   <= req_ch.ack_number;
         word_ff.adv_window   <= req_ch.adv_window;
         word_ff.syn_flag     <= req_ch.syn_flag;
         word_ff.ipv6_plen    <= req_ch.ipv6_plen;
         word_ff.old_checksum <= req_ch.old_checksum;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_word  = word_ff;

endmodule

@@ design/tswg_gate_core.sv @@
module tswg_gate_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  tswg_pkg::req_word_type word,
   input  tswg_pkg::cfg_type      cfg,
   output tswg_pkg::rsp_word_type result
);

   // incremental one's-complement update for a 32-bit field change
   function automatic logic [15:0] csum_update(input logic [15:0] check,
                                               input logic [31:0] old_v,
                                               input logic [31:0] new_v);
      logic [18:0] sum;
      logic [16:0] fold1;
      logic [15:0] fold2;
      sum = {3'b0, ~check} + {3'b0, ~old_v[31:16]} + {3'b0, ~old_v[15:0]}
          + {3'b0, new_v[31:16]} + {3'b0, new_v[15:0]};
      fold1 = {1'b0, sum[15:0]} + {14'b0, sum[18:16]};
      fold2 = fold1[15:0] + {15'b0, fold1[16]};
      return ~fold2;
   endfunction

   logic        entry_valid_ff, entry_valid_in;
   logic [31:0] send_seq_ff, send_seq_in;
   logic [31:0] acked_seq_ff, acked_seq_in;
   logic [15:0] peer_window_ff, peer_window_in;

   logic        flow_match;
   logic [15:0] seg_len;
   logic [31:0] seq_end;
   logic [31:0] window_end;
   logic        over_window;

   // flow lookup against the configured tuple
   assign flow_match = word.src_addr_hi == cfg.peer_addr_hi
                    && word.src_addr_lo == cfg.peer_addr_lo
                    && word.dst_addr_hi == cfg.local_addr_hi
                    && word.dst_addr_lo == cfg.local_addr_lo
                    && word.port_pair   == cfg.flow_ports;

   // send window test: length mod 2^16, sums mod 2^32, unsigned compare
   assign seg_len     = word.ipv6_plen - tswg_pkg::TCP_HDR_BYTES;
   assign seq_end     = send_seq_ff + {16'b0, seg_len};
   assign window_end  = acked_seq_ff + ({16'b0, peer_window_ff} << cfg.window_scale);
   assign over_window = seq_end > window_end;

   // verdict, rewrite and state update
   always_comb begin
      entry_valid_in      = entry_valid_ff;
      send_seq_in         = send_seq_ff;
      acked_seq_in        = acked_seq_ff;
      peer_window_in      = peer_window_ff;
      result.verdict      = tswg_pkg::VERDICT_PASS;
      result.out_seq      = '0;
      result.out_checksum = '0;
      case (word.mode)
         tswg_pkg::MODE_RX_TCP6: begin
            if (flow_match) begin
               if (!entry_valid_ff) begin
                  entry_valid_in = 1'b1;
                  send_seq_in    = word.ack_number;
               end
               acked_seq_in   = word.ack_number;
               peer_window_in = word.adv_window;
               result.verdict = cfg.flow_running ? tswg_pkg::VERDICT_DROP
                                                 : tswg_pkg::VERDICT_PASS;
            end
         end
         tswg_pkg::MODE_RX_OTHER: begin
            result.verdict = tswg_pkg::VERDICT_PASS;
         end
         tswg_pkg::MODE_TX: begin
            if (!entry_valid_ff) begin
               result.verdict = tswg_pkg::VERDICT_ABORT;
            end else if (over_window) begin
               result.verdict = tswg_pkg::VERDICT_DROP;
            end else begin
               result.verdict = tswg_pkg::VERDICT_FORWARD;
               result.out_seq = send_seq_ff;
               if (word.seq_number != send_seq_ff) begin
                  result.out_checksum = csum_update(word.old_checksum,
                                                    word.seq_number, send_seq_ff);
               end else begin
                  result.out_checksum = word.old_checksum;
               end
               send_seq_in = seq_end;
            end
         end
         default: begin
            result.verdict = tswg_pkg::VERDICT_ABORT;
         end
      endcase
   end

   // flow entry
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         send_seq_ff    <= '0;
         acked_seq_ff   <= '0;
         peer_window_ff <= '0;
      end else if (fire) begin
         entry_valid_ff <= entry_valid_in;
         send_seq_ff    <= send_seq_in;
         acked_seq_ff   <= acked_seq_in;
         peer_window_ff <= peer_window_in;
      end
   end

endmodule

@@ design/tswg_rsp_stage.sv @@
module tswg_rsp_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  tswg_pkg::rsp_word_type word,
   output logic                   rsp_free,
   tswg_rsp_if.source             rsp_ch
);

   logic                   valid_ff;
   logic                   valid_in;
   tswg_pkg::rsp_word_type word_ff;

   // result register is free when empty or being taken this cycle
   assign rsp_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.verdict      = word_ff.verdict;
   assign rsp_ch.out_seq      = word_ff.out_seq;
   assign rsp_ch.out_checksum = word_ff.out_checksum;

endmodule

@@ design/tcp_send_window_gate_unit.sv @@
// Send window gate for one IPv6 TCP flow. Received TCP6 segments that match the
// configured addresses and ports create the flow entry (send sequence taken from
// the ack) and record ack and window; they are dropped once flow_running is set
// and passed otherwise. Outgoing segments abort without a flow entry, are dropped
// when seq+len passes ack+(window<<scale), and otherwise get the tracked sequence
// number and an incrementally updated checksum and are forwarded. Each word
// returns exactly one result word. A word passes the input register, then the
// result register, and a new word is accepted every cycle while results are
// taken: the flow entry is updated in the same cycle the word is evaluated, so
// the next word already sees it. A result word that is not taken holds the
// result register and, behind it, the input register; input ready follows output
// ready in the same cycle, so the stall ends as soon as the result word is taken.
// Configuration writes are expected only while no word is in flight.
module tcp_send_window_gate_unit (
   input  logic                             clock,
   input  logic                             reset,
   tswg_req_if.sink                         req_ch,
   tswg_rsp_if.source                       rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [tswg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tswg_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   tswg_pkg::cfg_type      cfg;
   tswg_pkg::req_word_type stage_word;
   tswg_pkg::rsp_word_type result;
   logic                   stage_valid;
   logic                   rsp_free;
   logic                   fire;

   // word in the input register moves to the result register
   assign fire = stage_valid && rsp_free;

   tswg_csr_regs u_csr_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   tswg_req_stage u_req_stage (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_free    (rsp_free),
      .stage_valid (stage_valid),
      .stage_word  (stage_word)
   );

   tswg_gate_core u_gate_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .word   (stage_word),
      .cfg    (cfg),
      .result (result)
   );

   tswg_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (fire),
      .word     (result),
      .rsp_free (rsp_free),
      .rsp_ch   (rsp_ch)
   );

endmodule

@@ bench/tb_tcp_send_window_gate_unit.sv @@
module tb_tcp_send_window_gate_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT_NS = 2_000_000;

   logic                             clock;
   logic                             reset;
   logic                             csr_wr_en;
   logic [tswg_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tswg_pkg::CSR_DATA_W-1:0]  csr_wr_data;

   tswg_req_if req_ch();
   tswg_rsp_if rsp_ch();

   tcp_send_window_gate_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the flow registers and the flow entry
   tswg_pkg::cfg_type      flow_cfg;
   logic                   flow_valid;
   logic [31:0]            snd_nxt;
   logic [31:0]            snd_una;
   logic [15:0]            peer_wnd;

   tswg_pkg::rsp_word_type expected_verdicts[$];
   int                     mismatch_count;
   int                     burst_left;
   bit                     pacing_on;
   int                     rx_hold_req;

   // one's-complement checksum update for a rewritten 32-bit field
   function automatic logic [15:0] csum_rewrite(input logic [15:0] chk,
                                                input logic [31:0] old_v,
                                                input logic [31:0] new_v);
      logic [15:0] n_chk;
      logic [15:0] n_hi;
      logic [15:0] n_lo;
      logic [31:0] acc;
      n_chk = ~chk;
      n_hi  = ~old_v[31:16];
      n_lo  = ~old_v[15:0];
      acc = 32'(n_chk) + 32'(n_hi) + 32'(n_lo) + 32'(new_v[31:16]) + 32'(new_v[15:0]);
      acc = 32'(acc[15:0]) + 32'(acc[31:16]);
      acc = 32'(acc[15:0]) + 32'(acc[31:16]);
      return ~acc[15:0];
   endfunction

   // verdict for one accepted word, advancing the flow entry
   function automatic tswg_pkg::rsp_word_type gate_verdict_of(
         input tswg_pkg::req_word_type w);
      tswg_pkg::rsp_word_type r;
      logic [15:0]            seg_len;
      logic [31:0]            seg_end;
      logic [31:0]            wnd_end;
      logic                   hit;
      r = '0;
      r.verdict = tswg_pkg::VERDICT_PASS;
      hit = w.src_addr_hi == flow_cfg.peer_addr_hi &&
            w.src_addr_lo == flow_cfg.peer_addr_lo &&
            w.dst_addr_hi == flow_cfg.local_addr_hi &&
            w.dst_addr_lo == flow_cfg.local_addr_lo && w.port_pair == flow_cfg.flow_ports;
      case (w.mode)
         tswg_pkg::MODE_RX_TCP6: begin
            if (hit) begin
               if (!flow_valid) begin
                  flow_valid = 1'b1;
                  snd_nxt    = w.ack_number;
               end
               snd_una  = w.ack_number;
               peer_wnd = w.adv_window;
               if (flow_cfg.flow_running) r.verdict = tswg_pkg::VERDICT_DROP;
               else r.verdict = tswg_pkg::VERDICT_PASS;
            end
         end
         tswg_pkg::MODE_RX_OTHER: r.verdict = tswg_pkg::VERDICT_PASS;
         tswg_pkg::MODE_TX: begin
            if (!flow_valid) begin
               r.verdict = tswg_pkg::VERDICT_ABORT;
            end else begin
               seg_len = w.ipv6_plen - tswg_pkg::TCP_HDR_BYTES;
               seg_end = snd_nxt + 32'(seg_len);
               wnd_end = snd_una + (32'(peer_wnd) << flow_cfg.window_scale);
               if (seg_end > wnd_end) begin
                  r.verdict = tswg_pkg::VERDICT_DROP;
               end else begin
                  r.verdict = tswg_pkg::VERDICT_FORWARD;
                  r.out_seq = snd_nxt;
                  if (w.seq_number != snd_nxt)
                     r.out_checksum = csum_rewrite(w.old_checksum, w.seq_number, snd_nxt);
                  else
                     r.out_checksum = w.old_checksum;
                  snd_nxt = seg_end;
               end
            end
         end
         default: r.verdict = tswg_pkg::VERDICT_ABORT;
      endcase
      return r;
   endfunction

   task automatic flag_result(input string why, input tswg_pkg::rsp_word_type want,
                              input tswg_pkg::rsp_word_type got);
      if (mismatch_count < 10)
         $display({"%0t mismatch (%s): expected verdict %0d seq %h csum %h,",
                   " got verdict %0d seq %h csum %h"},
                  $realtime, why, want.verdict, want.out_seq, want.out_checksum,
                  got.verdict, got.out_seq, got.out_checksum);
      mismatch_count++;
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result check first, then prediction of the word accepted at this edge
   always @(posedge clock) begin : verdict_check
      tswg_pkg::req_word_type seen;
      tswg_pkg::rsp_word_type got;
      tswg_pkg::rsp_word_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.verdict      = tswg_pkg::verdict_type'(rsp_ch.verdict);
            got.out_seq      = rsp_ch.out_seq;
            got.out_checksum = rsp_ch.out_checksum;
            if (expected_verdicts.size() == 0) begin
               flag_result("no word expected", '0, got);
            end else begin
               want = expected_verdicts.pop_front();
               if (got.verdict !== want.verdict || got.out_seq !== want.out_seq ||
                   got.out_checksum !== want.out_checksum)
                  flag_result("field", want, got);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.mode         = tswg_pkg::mode_type'(req_ch.mode);
            seen.src_addr_hi  = req_ch.src_addr_hi;
            seen.src_addr_lo  = req_ch.src_addr_lo;
            seen.dst_addr_hi  = req_ch.dst_addr_hi;
            seen.dst_addr_lo  = req_ch.dst_addr_lo;
            seen.port_pair    = req_ch.port_pair;
            seen.seq_number   = req_ch.seq_number;
            seen.ack_number   = req_ch.ack_number;
            seen.adv_window   = req_ch.adv_window;
            seen.syn_flag     = req_ch.syn_flag;
            seen.ipv6_plen    = req_ch.ipv6_plen;
            seen.old_checksum = req_ch.old_checksum;
            expected_verdicts.push_back(gate_verdict_of(seen));
         end
      end
   end

   // receiver: random stall pattern, plus long hold-offs on request
   initial begin : rsp_drain
      int pattern_left;
      int stall_pct;
      int hold_left;
      pattern_left = 0;
      stall_pct    = 0;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_req > 0) begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
         end
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(16, 200);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         pattern_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("tcp_send_window_gate_unit regression: fail");
      $finish;
   end

   // offer one word, with burst pacing when pacing_on is set, and wait until it is taken
   task automatic send_word(input tswg_pkg::req_word_type w);
      int gap;
      if (pacing_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
               @(negedge clock);
               req_ch.valid <= 1'b0;
            end
         end
         burst_left--;
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= w.mode;
      req_ch.src_addr_hi  <= w.src_addr_hi;
      req_ch.src_addr_lo  <= w.src_addr_lo;
      req_ch.dst_addr_hi  <= w.dst_addr_hi;
      req_ch.dst_addr_lo  <= w.dst_addr_lo;
      req_ch.port_pair    <= w.port_pair;
      req_ch.seq_number   <= w.seq_number;
      req_ch.ack_number   <= w.ack_number;
      req_ch.adv_window   <= w.adv_window;
      req_ch.syn_flag     <= w.syn_flag;
      req_ch.ipv6_plen    <= w.ipv6_plen;
      req_ch.old_checksum <= w.old_checksum;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop offering and let every outstanding word come back
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input tswg_pkg::csr_index_type idx,
                            input logic [tswg_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         tswg_pkg::CSR_PEER_ADDR_HI:  flow_cfg.peer_addr_hi  = data;
         tswg_pkg::CSR_PEER_ADDR_LO:  flow_cfg.peer_addr_lo  = data;
         tswg_pkg::CSR_LOCAL_ADDR_HI: flow_cfg.local_addr_hi = data;
         tswg_pkg::CSR_LOCAL_ADDR_LO: flow_cfg.local_addr_lo = data;
         tswg_pkg::CSR_FLOW_PORTS:    flow_cfg.flow_ports    = data[31:0];
         tswg_pkg::CSR_WINDOW_SCALE:  flow_cfg.window_scale  = data[3:0];
         tswg_pkg::CSR_FLOW_RUNNING:  flow_cfg.flow_running  = data[0];
         default: ;
      endcase
   endtask

   task automatic write_flow(input tswg_pkg::cfg_type c);
      write_reg(tswg_pkg::CSR_PEER_ADDR_HI, c.peer_addr_hi);
      write_reg(tswg_pkg::CSR_PEER_ADDR_LO, c.peer_addr_lo);
      write_reg(tswg_pkg::CSR_LOCAL_ADDR_HI, c.local_addr_hi);
      write_reg(tswg_pkg::CSR_LOCAL_ADDR_LO, c.local_addr_lo);
      write_reg(tswg_pkg::CSR_FLOW_PORTS, 64'(c.flow_ports));
      write_reg(tswg_pkg::CSR_WINDOW_SCALE, 64'(c.window_scale));
      write_reg(tswg_pkg::CSR_FLOW_RUNNING, 64'(c.flow_running));
   endtask

   // fully random word
   function automatic tswg_pkg::req_word_type noise_word();
      tswg_pkg::req_word_type w;
      w.mode         = tswg_pkg::mode_type'($urandom_range(0, 3));
      w.src_addr_hi  = {$urandom, $urandom};
      w.src_addr_lo  = {$urandom, $urandom};
      w.dst_addr_hi  = {$urandom, $urandom};
      w.dst_addr_lo  = {$urandom, $urandom};
      w.port_pair    = $urandom;
      w.seq_number   = $urandom;
      w.ack_number   = $urandom;
      w.adv_window   = 16'($urandom);
      w.syn_flag     = 1'($urandom_range(0, 1));
      w.ipv6_plen    = 16'($urandom);
      w.old_checksum = 16'($urandom);
      return w;
   endfunction

   // random word carrying the configured flow's addresses and ports
   function automatic tswg_pkg::req_word_type flow_word(input tswg_pkg::mode_type m);
      tswg_pkg::req_word_type w;
      w = noise_word();
      w.mode        = m;
      w.src_addr_hi = flow_cfg.peer_addr_hi;
      w.src_addr_lo = flow_cfg.peer_addr_lo;
      w.dst_addr_hi = flow_cfg.local_addr_hi;
      w.dst_addr_lo = flow_cfg.local_addr_lo;
      w.port_pair   = flow_cfg.flow_ports;
      return w;
   endfunction

   // mostly well-formed flow traffic, with near misses and noise
   function automatic tswg_pkg::req_word_type traffic_word();
      tswg_pkg::req_word_type w;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         w = flow_word(tswg_pkg::MODE_RX_TCP6);
         if ($urandom_range(0, 19) != 0) w.ack_number = snd_nxt - $urandom_range(0, 3000);
         case ($urandom_range(0, 3))
            0: w.adv_window = 16'($urandom_range(0, 4000));
            1: w.adv_window = 16'hFFFF;
            default: ;
         endcase
      end else if (pick < 70) begin
         w = flow_word(tswg_pkg::MODE_TX);
         if ($urandom_range(0, 1) != 0) w.seq_number = snd_nxt;
         if ($urandom_range(0, 9) != 0)
            w.ipv6_plen = tswg_pkg::TCP_HDR_BYTES + 16'($urandom_range(0, 1500));
      end else if (pick < 80) begin
         // received segment off by a single bit in its flow key
         w = flow_word(tswg_pkg::MODE_RX_TCP6);
         case ($urandom_range(0, 4))
            0: w.src_addr_hi ^= 64'd1 << $urandom_range(0, 63);
            1: w.src_addr_lo ^= 64'd1 << $urandom_range(0, 63);
            2: w.dst_addr_hi ^= 64'd1 << $urandom_range(0, 63);
            3: w.dst_addr_lo ^= 64'd1 << $urandom_range(0, 63);
            default: w.port_pair ^= 32'd1 << $urandom_range(0, 31);
         endcase
      end else if (pick < 85) begin
         w = flow_word(tswg_pkg::MODE_RX_OTHER);
      end else if (pick < 90) begin
         w = flow_word(tswg_pkg::MODE_TX_TRUNC);
      end else begin
         w = noise_word();
      end
      return w;
   endfunction

   // no flow entry yet: outgoing aborts, other kinds pass
   task automatic test_reset_defaults();
      tswg_pkg::req_word_type w;
      send_word(flow_word(tswg_pkg::MODE_TX));
      send_word(flow_word(tswg_pkg::MODE_TX_TRUNC));
      send_word(flow_word(tswg_pkg::MODE_RX_OTHER));
      w = flow_word(tswg_pkg::MODE_RX_TCP6);
      w.src_addr_hi ^= 64'd1;
      send_word(w);
      wait_idle();
   endtask

   // entry creation near the top of sequence space and window boundaries
   task automatic test_window_edges();
      tswg_pkg::cfg_type      c;
      tswg_pkg::req_word_type w;
      c.peer_addr_hi  = '1;
      c.peer_addr_lo  = '0;
      c.local_addr_hi = {$urandom, $urandom};
      c.local_addr_lo = '1;
      c.flow_ports    = 32'hFFFF_0000;
      c.window_scale  = 4'd0;
      c.flow_running  = 1'b0;
      write_flow(c);
      w = flow_word(tswg_pkg::MODE_RX_TCP6);
      w.ack_number = 32'hFFFF_FFF0;
      w.adv_window = 16'd100;
      w.syn_flag   = 1'b1;
      send_word(w);
      // sequence unchanged, end wraps past zero
      w = flow_word(tswg_pkg::MODE_TX);
      w.seq_number   = 32'hFFFF_FFF0;
      w.ipv6_plen    = tswg_pkg::TCP_HDR_BYTES + 16'd32;
      w.old_checksum = 16'hFFFF;
      send_word(w);
      w = flow_word(tswg_pkg::MODE_TX);
      w.seq_number   = 32'h1234_5678;
      w.ipv6_plen    = tswg_pkg::TCP_HDR_BYTES;
      w.old_checksum = 16'h0000;
      send_word(w);
      // short payload wraps the length
      w = flow_word(tswg_pkg::MODE_TX);
      w.ipv6_plen = tswg_pkg::TCP_HDR_BYTES - 16'd1;
      send_word(w);
      // exactly filling the window, then one byte over
      w = flow_word(tswg_pkg::MODE_TX);
      w.ipv6_plen = tswg_pkg::TCP_HDR_BYTES + 16'd68;
      send_word(w);
      w = flow_word(tswg_pkg::MODE_TX);
      w.ipv6_plen = tswg_pkg::TCP_HDR_BYTES + 16'd1;
      send_word(w);
      // zero window
      w = flow_word(tswg_pkg::MODE_RX_TCP6);
      w.ack_number = 32'h0000_0054;
      w.adv_window = 16'd0;
      w.syn_flag   = 1'b0;
      send_word(w);
      w = flow_word(tswg_pkg::MODE_TX);
      w.ipv6_plen = tswg_pkg::TCP_HDR_BYTES;
      send_word(w);
      w = flow_word(tswg_pkg::MODE_TX);
      w.ipv6_plen = tswg_pkg::TCP_HDR_BYTES + 16'd1;
      send_word(w);
      // full window, largest payload
      w = flow_word(tswg_pkg::MODE_RX_TCP6);
      w.ack_number = 32'h0000_0054;
      w.adv_window = 16'hFFFF;
      send_word(w);
      w = flow_word(tswg_pkg::MODE_TX);
      w.ipv6_plen = 16'hFFFF;
      send_word(w);
      wait_idle();
   endtask

   // largest scale, then running flow drops matching received segments
   task automatic test_scale_and_running();
      tswg_pkg::req_word_type w;
      write_reg(tswg_pkg::CSR_WINDOW_SCALE, 64'd15);
      w = flow_word(tswg_pkg::MODE_RX_TCP6);
      w.ack_number = snd_nxt;
      w.adv_window = 16'hFFFF;
      send_word(w);
      w = flow_word(tswg_pkg::MODE_TX);
      w.ipv6_plen = 16'hFFFF;
      send_word(w);
      wait_idle();
      write_reg(tswg_pkg::CSR_WINDOW_SCALE, 64'd14);
      write_reg(tswg_pkg::CSR_FLOW_RUNNING, 64'd1);
      send_word(flow_word(tswg_pkg::MODE_RX_TCP6));
      w = flow_word(tswg_pkg::MODE_RX_TCP6);
      w.dst_addr_lo ^= 64'd1 << 63;
      send_word(w);
      w = flow_word(tswg_pkg::MODE_RX_TCP6);
      w.port_pair ^= 32'h0001_0000;
      send_word(w);
      send_word(flow_word(tswg_pkg::MODE_RX_OTHER));
      send_word(flow_word(tswg_pkg::MODE_TX_TRUNC));
      wait_idle();
   endtask

   // random traffic over a series of flow settings
   task automatic test_random_traffic();
      tswg_pkg::cfg_type c;
      for (int ph = 0; ph < 7; ph++) begin
         case (ph % 3)
            0: begin
               c.peer_addr_hi  = '0;
               c.peer_addr_lo  = '0;
               c.local_addr_hi = '0;
               c.local_addr_lo = '0;
            end
            1: begin
               c.peer_addr_hi  = '1;
               c.peer_addr_lo  = '1;
               c.local_addr_hi = '1;
               c.local_addr_lo = '1;
            end
            default: begin
               c.peer_addr_hi  = {$urandom, $urandom};
               c.peer_addr_lo  = {$urandom, $urandom};
               c.local_addr_hi = {$urandom, $urandom};
               c.local_addr_lo = {$urandom, $urandom};
            end
         endcase
         case (ph % 4)
            0: c.flow_ports = 32'h0000_0000;
            1: c.flow_ports = 32'hFFFF_FFFF;
            default: c.flow_ports = $urandom;
         endcase
         case (ph)
            0: c.window_scale = 4'd0;
            1: c.window_scale = 4'd15;
            2: c.window_scale = 4'd14;
            3: c.window_scale = 4'd7;
            4: c.window_scale = 4'd1;
            default: c.window_scale = 4'($urandom_range(0, 15));
         endcase
         c.flow_running = (ph == 1 || ph == 4);
         write_flow(c);
         repeat (250) send_word(traffic_word());
         wait_idle();
      end
   endtask

   // receiver holds off while words keep coming, so the input stalls
   task automatic test_output_backpressure();
      pacing_on   = 1'b0;
      rx_hold_req = 400;
      repeat (60) send_word(traffic_word());
      pacing_on = 1'b1;
      wait_idle();
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wr_data         = '0;
      req_ch.valid        = 1'b0;
      req_ch.mode         = '0;
      req_ch.src_addr_hi  = '0;
      req_ch.src_addr_lo  = '0;
      req_ch.dst_addr_hi  = '0;
      req_ch.dst_addr_lo  = '0;
      req_ch.port_pair    = '0;
      req_ch.seq_number   = '0;
      req_ch.ack_number   = '0;
      req_ch.adv_window   = '0;
      req_ch.syn_flag     = 1'b0;
      req_ch.ipv6_plen    = '0;
      req_ch.old_checksum = '0;
      flow_cfg            = '0;
      flow_valid          = 1'b0;
      snd_nxt             = '0;
      snd_una             = '0;
      peer_wnd            = '0;
      mismatch_count      = 0;
      burst_left          = 0;
      pacing_on           = 1'b1;
      rx_hold_req         = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_window_edges();
      test_scale_and_running();
      test_output_backpressure();
      test_random_traffic();

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("tcp_send_window_gate_unit regression: pass");
      end else begin
         $display("tcp_send_window_gate_unit regression: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/tswg_pkg.sv
design/tswg_req_if.sv
design/tswg_rsp_if.sv
design/tswg_csr_regs.sv
design/tswg_req_stage.sv
design/tswg_gate_core.sv
design/tswg_rsp_stage.sv
design/tcp_send_window_gate_unit.sv
bench/tb_tcp_send_window_gate_unit.sv
